>>> design/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types and constants for the signed fixed-width ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package sfa_pkg;

  localparam int unsigned WIDTH_DEF = 64;
  localparam int unsigned PORT_W    = 64;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_NEG = 3'd2,
    ACT_ABS = 3'd3,
    ACT_MUL = 3'd4,
    ACT_DIV = 3'd5,
    ACT_CMP = 3'd6
  } action_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  act;
    logic        q_neg;
    logic        r_neg;
    logic        derr;
    logic        s;
    logic        v;
    logic        z;
  } ctl_t;

endpackage
`default_nettype wire

>>> design/sfa_front.sv
// ----------------------------------------------------------------------------
// sfa_front
// Input stage: masks operands, forms simple results, compare flags and the
// operands of the multiply and divide cell row.
// ----------------------------------------------------------------------------
`default_nettype none
module sfa_front #(
  parameter int unsigned WIDTH = sfa_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [2:0]                  in_action,
  input  wire logic [sfa_pkg::PORT_W-1:0]  in_operand_a,
  input  wire logic [sfa_pkg::PORT_W-1:0]  in_operand_b,
  output sfa_pkg::ctl_t                    ctl_o,
  output logic [WIDTH-1:0]                 dq_o,
  output logic [WIDTH-1:0]                 rem_o,
  output logic [WIDTH-1:0]                 mb_o,
  output logic [WIDTH-1:0]                 mcand_o,
  output logic [WIDTH-1:0]                 mplier_o,
  output logic [WIDTH-1:0]                 prod_o
);

  sfa_pkg::ctl_t    ctl_r, ctl_nxt;
  logic [WIDTH-1:0] dq_r, dq_nxt, mb_r, mb_nxt;
  logic [WIDTH-1:0] mcand_r, mcand_nxt, mplier_r, mplier_nxt, prod_r, prod_nxt;
  logic [WIDTH-1:0] a, b, diff, neg_a, neg_b, mag_a, mag_b;

  always_comb begin
    a      = in_operand_a[WIDTH-1:0];
    b      = in_operand_b[WIDTH-1:0];
    diff   = a - b;
    neg_a  = '0 - a;
    neg_b  = '0 - b;
    mag_a  = a[WIDTH-1] ? neg_a : a;
    mag_b  = b[WIDTH-1] ? neg_b : b;

    ctl_nxt       = '0;
    ctl_nxt.valid = in_valid;
    ctl_nxt.act   = in_action;
    dq_nxt        = '0;
    mb_nxt        = '0;
    mcand_nxt     = '0;
    mplier_nxt    = '0;
    prod_nxt      = '0;

    case (sfa_pkg::action_t'(in_action))
      sfa_pkg::ACT_ADD: prod_nxt = a + b;
      sfa_pkg::ACT_SUB: prod_nxt = diff;
      sfa_pkg::ACT_NEG: prod_nxt = neg_a;
      sfa_pkg::ACT_ABS: prod_nxt = mag_a;
      sfa_pkg::ACT_MUL: begin
        mcand_nxt  = a;
        mplier_nxt = b;
      end
      sfa_pkg::ACT_DIV: begin
        dq_nxt        = mag_a;
        mb_nxt        = mag_b;
        ctl_nxt.q_neg = a[WIDTH-1] ^ b[WIDTH-1];
        ctl_nxt.r_neg = a[WIDTH-1];
        ctl_nxt.derr  = (b == '0);
      end
      sfa_pkg::ACT_CMP: begin
        ctl_nxt.s = diff[WIDTH-1];
        ctl_nxt.v = ((a ^ b) & (a ^ diff)) >> (WIDTH - 1) != '0;
        ctl_nxt.z = (diff == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq_r     <= dq_nxt;
      mb_r     <= mb_nxt;
      mcand_r  <= mcand_nxt;
      mplier_r <= mplier_nxt;
      prod_r   <= prod_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign dq_o     = dq_r;
  assign rem_o    = '0;
  assign mb_o     = mb_r;
  assign mcand_o  = mcand_r;
  assign mplier_o = mplier_r;
  assign prod_o   = prod_r;

endmodule
`default_nettype wire

>>> design/sfa_cell.sv
// ----------------------------------------------------------------------------
// sfa_cell
// One cell of the row: one restoring divide step and one shift-add
// multiply step per cycle while adv lets the pipe advance.
// ----------------------------------------------------------------------------
`default_nettype none
module sfa_cell #(
  parameter int unsigned WIDTH = sfa_pkg::WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  sfa_pkg::ctl_t           ctl_i,
  input  wire logic [WIDTH-1:0]   dq_i,
  input  wire logic [WIDTH-1:0]   rem_i,
  input  wire logic [WIDTH-1:0]   mb_i,
  input  wire logic [WIDTH-1:0]   mcand_i,
  input  wire logic [WIDTH-1:0]   mplier_i,
  input  wire logic [WIDTH-1:0]   prod_i,
  output sfa_pkg::ctl_t           ctl_o,
  output logic [WIDTH-1:0]        dq_o,
  output logic [WIDTH-1:0]        rem_o,
  output logic [WIDTH-1:0]        mb_o,
  output logic [WIDTH-1:0]        mcand_o,
  output logic [WIDTH-1:0]        mplier_o,
  output logic [WIDTH-1:0]        prod_o
);

  sfa_pkg::ctl_t    ctl_r;
  logic [WIDTH-1:0] dq_r, dq_nxt, rem_r, rem_nxt, mb_r;
  logic [WIDTH-1:0] mcand_r, mplier_r, prod_r, prod_nxt;
  logic [WIDTH:0]   trial, diff;
  logic             qbit;

  always_comb begin
    trial   = {rem_i, dq_i[WIDTH-1]};
    diff    = trial - {1'b0, mb_i};
    qbit    = !diff[WIDTH];
    rem_nxt = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    dq_nxt  = {dq_i[WIDTH-2:0], qbit};
    prod_nxt = mplier_i[0] ? prod_i + mcand_i : prod_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dq_r     <= dq_nxt;
      rem_r    <= rem_nxt;
      mb_r     <= mb_i;
      mcand_r  <= {mcand_i[WIDTH-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_i[WIDTH-1:1]};
      prod_r   <= prod_nxt;
    end
  end

  assign ctl_o    = ctl_r;
  assign dq_o     = dq_r;
  assign rem_o    = rem_r;
  assign mb_o     = mb_r;
  assign mcand_o  = mcand_r;
  assign mplier_o = mplier_r;
  assign prod_o   = prod_r;

endmodule
`default_nettype wire

>>> design/signed_fixed_width_alu_top.sv
// ----------------------------------------------------------------------------
// signed_fixed_width_alu_top
// Two's complement ALU: add, subtract, negate, absolute, multiply, divide
// with remainder and compare, all wrapped to WIDTH bits.
// ----------------------------------------------------------------------------
// Fully pipelined: one word accepted per cycle unless the pipe is held; each
// result passes the input stage, a row of WIDTH cells that each retire one
// quotient bit and one multiplier bit, and the output stage. The whole pipe
// holds while a result waits on out_stall.
`default_nettype none
module signed_fixed_width_alu_top #(
  parameter int unsigned WIDTH = sfa_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_action,
  input  wire logic [sfa_pkg::PORT_W-1:0]  in_operand_a,
  input  wire logic [sfa_pkg::PORT_W-1:0]  in_operand_b,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sfa_pkg::PORT_W-1:0]       out_result,
  output logic [sfa_pkg::PORT_W-1:0]       out_remainder,
  output logic                             out_flag_sign,
  output logic                             out_flag_overflow,
  output logic                             out_flag_zero,
  output logic                             out_is_less,
  output logic                             out_is_less_equal,
  output logic                             out_is_greater,
  output logic                             out_is_greater_equal,
  output logic                             out_is_equal,
  output logic                             out_divide_error
);

  sfa_pkg::ctl_t    ctl    [0:WIDTH];
  logic [WIDTH-1:0] dq     [0:WIDTH];
  logic [WIDTH-1:0] rem    [0:WIDTH];
  logic [WIDTH-1:0] mb     [0:WIDTH];
  logic [WIDTH-1:0] mcand  [0:WIDTH];
  logic [WIDTH-1:0] mplier [0:WIDTH];
  logic [WIDTH-1:0] prod   [0:WIDTH];

  logic             adv;
  logic             out_valid_r;
  logic [WIDTH-1:0] res_r, res_nxt, rmd_r, rmd_nxt;
  logic [7:0]       flg_r, flg_nxt;
  logic             lt;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  sfa_front #(.WIDTH(WIDTH)) u_front (
    .clk, .rst_n, .adv, .in_valid, .in_action, .in_operand_a, .in_operand_b,
    .ctl_o(ctl[0]), .dq_o(dq[0]), .rem_o(rem[0]), .mb_o(mb[0]),
    .mcand_o(mcand[0]), .mplier_o(mplier[0]), .prod_o(prod[0])
  );

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    sfa_cell #(.WIDTH(WIDTH)) u_cell (
      .clk, .rst_n, .adv,
      .ctl_i(ctl[i]), .dq_i(dq[i]), .rem_i(rem[i]), .mb_i(mb[i]),
      .mcand_i(mcand[i]), .mplier_i(mplier[i]), .prod_i(prod[i]),
      .ctl_o(ctl[i+1]), .dq_o(dq[i+1]), .rem_o(rem[i+1]), .mb_o(mb[i+1]),
      .mcand_o(mcand[i+1]), .mplier_o(mplier[i+1]), .prod_o(prod[i+1])
    );
  end

  always_comb begin
    res_nxt = prod[WIDTH];
    rmd_nxt = '0;
    flg_nxt = '0;
    lt      = ctl[WIDTH].s ^ ctl[WIDTH].v;
    case (ctl[WIDTH].act)
      sfa_pkg::ACT_DIV: begin
        if (ctl[WIDTH].derr) begin
          res_nxt = '0;
        end else begin
          res_nxt = ctl[WIDTH].q_neg ? '0 - dq[WIDTH] : dq[WIDTH];
          rmd_nxt = ctl[WIDTH].r_neg ? '0 - rem[WIDTH] : rem[WIDTH];
        end
      end
      sfa_pkg::ACT_CMP: begin
        flg_nxt = {ctl[WIDTH].s, ctl[WIDTH].v, ctl[WIDTH].z, lt,
                   lt || ctl[WIDTH].z, !lt && !ctl[WIDTH].z, !lt, ctl[WIDTH].z};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl[WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r            <= res_nxt;
      rmd_r            <= rmd_nxt;
      flg_r            <= flg_nxt;
      out_divide_error <= ctl[WIDTH].derr;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result           = sfa_pkg::PORT_W'($signed(res_r));
  assign out_remainder        = sfa_pkg::PORT_W'($signed(rmd_r));
  assign out_flag_sign        = flg_r[7];
  assign out_flag_overflow    = flg_r[6];
  assign out_flag_zero        = flg_r[5];
  assign out_is_less          = flg_r[4];
  assign out_is_less_equal    = flg_r[3];
  assign out_is_greater       = flg_r[2];
  assign out_is_greater_equal = flg_r[1];
  assign out_is_equal         = flg_r[0];

`ifndef SYNTHESIS
  a_derr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_error |-> out_result == '0 && out_remainder == '0)
    else $error("divide error with nonzero result");
  a_eq_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_equal |-> out_flag_zero && !out_is_less && !out_is_greater)
    else $error("equal relation inconsistent");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire
